/* rtl/mexp_pkg.sv */
// Shared types and constants for the modular exponentiation block.
package mexp_pkg;

    // Field widths fixed by the interface.
    localparam int BASE_W = 32;
    localparam int EXP_W  = 32;
    localparam int MOD_W  = 31;

    // Multiplier operand is scanned one bit per cycle, most significant first.
    localparam int OPY_W = 32;
    localparam int CNT_W = 6;

    // Bit counts for the two kinds of operation on the shared unit.
    localparam logic [CNT_W-1:0] NBITS_REDUCE  = CNT_W'(OPY_W);
    localparam logic [CNT_W-1:0] NBITS_PRODUCT = CNT_W'(MOD_W);

    // Modulus after reset: ten to the ninth plus seven.
    localparam logic [MOD_W-1:0] MODULUS_RESET = 31'd1000000007;

    // Configuration register byte address.
    localparam int ADDR_W = 2;
    localparam logic [ADDR_W-1:0] ADDR_MODULUS = 2'd0;

    // Request to the shared modular multiplier.
    typedef struct packed {
        logic              start;
        logic [MOD_W-1:0]  x;
        logic [OPY_W-1:0]  y;
        logic [CNT_W-1:0]  nbits;
    } mexp_req_t;

    // Response from the shared modular multiplier.
    typedef struct packed {
        logic              done;
        logic [MOD_W-1:0]  result;
    } mexp_rsp_t;

endpackage

/* rtl/mexp_if.sv */
// Valid/ready channel interfaces for input and result words.
interface mexp_in_if import mexp_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [BASE_W-1:0] base;
    logic [EXP_W-1:0]  exponent;

    modport source (output valid, output base, output exponent, input ready);
    modport sink   (input valid, input base, input exponent, output ready);
endinterface

interface mexp_out_if import mexp_pkg::*; ();
    logic             valid;
    logic             ready;
    logic [MOD_W-1:0] power_result;

    modport source (output valid, output power_result, input ready);
    modport sink   (input valid, input power_result, output ready);
endinterface

/* rtl/modular_exponentiation.sv */
// Top level: right-to-left square-and-multiply modular exponentiation.
// Computes base^exponent mod modulus, one word at a time. The base is first
// reduced by the shared bit-serial modular multiplier, then each exponent bit
// below the highest set bit costs a square and, for a set bit, a multiply, on
// that same unit; the highest set bit costs only a multiply. A modulus below
// two skips the multiplier and answers zero. An exponent of zero still pays for
// the base reduction. Only the low EXP_BITS exponent bits are used. The input
// is not ready while a word is in work; a finished result sits in an output
// register, so the next word can be taken while the result waits. Write the
// modulus only while the block is idle.
module modular_exponentiation import mexp_pkg::*; #(
    parameter int EXP_BITS = 32
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [31:0]       pwdata,
    output logic [31:0]       prdata,
    output logic              pready,
    mexp_in_if.sink           in_ch,
    mexp_out_if.source        out_ch
);

    localparam int EXP_SCAN = (EXP_BITS < EXP_W) ? EXP_BITS : EXP_W;
    localparam logic [EXP_W-1:0] EXP_MASK =
        (EXP_SCAN >= EXP_W) ? {EXP_W{1'b1}} : ((EXP_W'(1) << EXP_SCAN) - EXP_W'(1));

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_RED   = 3'd1;
    localparam logic [2:0] ST_CHECK = 3'd2;
    localparam logic [2:0] ST_MUL   = 3'd3;
    localparam logic [2:0] ST_SQR   = 3'd4;
    localparam logic [2:0] ST_OUT   = 3'd5;

    logic [MOD_W-1:0] modulus;
    mexp_req_t        req_reg, req_next;
    mexp_rsp_t        rsp;

    logic [2:0]       state_reg, state_next;
    logic [MOD_W-1:0] acc_reg, acc_next;
    logic [MOD_W-1:0] sq_reg, sq_next;
    logic [EXP_W-1:0] exp_reg, exp_next;
    logic             out_valid_reg, out_valid_next;
    logic [MOD_W-1:0] result_reg, result_next;
    logic             in_fire;
    logic             out_free;

    mexp_apb u_apb (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .modulus (modulus)
    );

    mexp_mulmod u_mulmod (
        .clk     (clk),
        .rst_n   (rst_n),
        .modulus (modulus),
        .req     (req_reg),
        .rsp     (rsp)
    );

    assign in_ch.ready = (state_reg == ST_IDLE);
    assign in_fire     = in_ch.valid && in_ch.ready;
    assign out_free    = !out_valid_reg || out_ch.ready;

    // Sequencer: reduce the base, then walk the exponent bits on the shared unit.
    always_comb
    begin
        state_next     = state_reg;
        acc_next       = acc_reg;
        sq_next        = sq_reg;
        exp_next       = exp_reg;
        req_next       = req_reg;
        req_next.start = 1'b0;
        out_valid_next = out_valid_reg;
        result_next    = result_reg;

        if (out_valid_reg && out_ch.ready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (in_fire)
                begin
                    exp_next = in_ch.exponent & EXP_MASK;
                    acc_next = MOD_W'(1);
                    if (modulus < MOD_W'(2))
                    begin
                        acc_next   = '0;
                        state_next = ST_OUT;
                    end
                    else
                    begin
                        req_next.start = 1'b1;
                        req_next.x     = MOD_W'(1);
                        req_next.y     = in_ch.base;
                        req_next.nbits = NBITS_REDUCE;
                        state_next     = ST_RED;
                    end
                end
            end
            ST_RED:
            begin
                if (rsp.done)
                begin
                    sq_next    = rsp.result;
                    state_next = ST_CHECK;
                end
            end
            ST_CHECK:
            begin
                req_next.nbits = NBITS_PRODUCT;
                if (exp_reg == '0)
                begin
                    state_next = ST_OUT;
                end
                else if (exp_reg[0])
                begin
                    req_next.start = 1'b1;
                    req_next.x     = acc_reg;
                    req_next.y     = {sq_reg, 1'b0};
                    state_next     = ST_MUL;
                end
                else
                begin
                    req_next.start = 1'b1;
                    req_next.x     = sq_reg;
                    req_next.y     = {sq_reg, 1'b0};
                    state_next     = ST_SQR;
                end
            end
            ST_MUL:
            begin
                if (rsp.done)
                begin
                    acc_next = rsp.result;
                    if (exp_reg[EXP_W-1:1] == '0)
                    begin
                        state_next = ST_OUT;
                    end
                    else
                    begin
                        req_next.start = 1'b1;
                        req_next.x     = sq_reg;
                        req_next.y     = {sq_reg, 1'b0};
                        req_next.nbits = NBITS_PRODUCT;
                        state_next     = ST_SQR;
                    end
                end
            end
            ST_SQR:
            begin
                if (rsp.done)
                begin
                    sq_next    = rsp.result;
                    exp_next   = {1'b0, exp_reg[EXP_W-1:1]};
                    state_next = ST_CHECK;
                end
            end
            ST_OUT:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    result_next    = acc_reg;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
            req_reg       <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            req_reg       <= req_next;
        end
    end

    always_ff @(posedge clk)
    begin
        acc_reg    <= acc_next;
        sq_reg     <= sq_next;
        exp_reg    <= exp_next;
        result_reg <= result_next;
    end

    assign out_ch.valid        = out_valid_reg;
    assign out_ch.power_result = result_reg;

endmodule

/* rtl/mexp_mulmod.sv */
// Bit-serial interleaved modular multiplier: (x * y) mod m, one y bit per cycle.
module mexp_mulmod import mexp_pkg::*; (
    input  logic             clk,
    input  logic             rst_n,
    input  logic [MOD_W-1:0] modulus,
    input  mexp_req_t        req,
    output mexp_rsp_t        rsp
);

    logic [MOD_W-1:0] acc_reg, acc_next;
    logic [MOD_W-1:0] x_reg, x_next;
    logic [OPY_W-1:0] y_reg, y_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             busy_reg, busy_next;
    logic             done_reg, done_next;

    logic [MOD_W:0] dbl;
    logic [MOD_W:0] dbl_red;
    logic [MOD_W:0] sum;
    logic [MOD_W:0] sum_red;
    logic [MOD_W:0] mod_ext;

    // One step: double the partial result, reduce, add x when the bit is set, reduce.
    // The partial result stays below m, so each reduction needs one subtract at most.
    always_comb
    begin
        mod_ext = {1'b0, modulus};
        dbl     = {acc_reg, 1'b0};
        dbl_red = (dbl >= mod_ext) ? (dbl - mod_ext) : dbl;
        sum     = dbl_red + (y_reg[OPY_W-1] ? {1'b0, x_reg} : '0);
        sum_red = (sum >= mod_ext) ? (sum - mod_ext) : sum;
    end

    // Sequencing of the bit scan.
    always_comb
    begin
        acc_next  = acc_reg;
        x_next    = x_reg;
        y_next    = y_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (req.start)
        begin
            acc_next  = '0;
            x_next    = req.x;
            y_next    = req.y;
            cnt_next  = req.nbits;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            acc_next = sum_red[MOD_W-1:0];
            y_next   = {y_reg[OPY_W-2:0], 1'b0};
            cnt_next = cnt_reg - CNT_W'(1);
            if (cnt_reg == CNT_W'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        acc_reg <= acc_next;
        x_reg   <= x_next;
        y_reg   <= y_next;
    end

    assign rsp.done   = done_reg;
    assign rsp.result = acc_reg;

endmodule

/* rtl/mexp_apb.sv */
// APB configuration port holding the modulus register.
module mexp_apb import mexp_pkg::*; (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [31:0]       pwdata,
    output logic [31:0]       prdata,
    output logic              pready,
    output logic [MOD_W-1:0]  modulus
);

    logic [MOD_W-1:0] modulus_reg, modulus_next;

    // Write in the access phase when the address selects the modulus.
    always_comb
    begin
        modulus_next = modulus_reg;
        if (psel && penable && pwrite && (paddr == ADDR_MODULUS))
        begin
            modulus_next = pwdata[MOD_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            modulus_reg <= MODULUS_RESET;
        end
        else
        begin
            modulus_reg <= modulus_next;
        end
    end

    // Read back; unmapped addresses return zero.
    always_comb
    begin
        prdata = '0;
        if (paddr == ADDR_MODULUS)
        begin
            prdata = {1'b0, modulus_reg};
        end
    end

    assign pready  = 1'b1;
    assign modulus = modulus_reg;

endmodule

/* tb/sv/modular_exponentiation_tb.sv */
// Self-checking testbench for the modular exponentiation block over valid/ready words and APB.
module modular_exponentiation_tb;
    import mexp_pkg::*;

    localparam int EXP_BITS       = 32;
    localparam int HOLD_CYCLES    = 5000;
    localparam int DRAIN_CYCLES   = 2200;
    localparam int WATCHDOG_LIMIT = 30000;

    // One input word: a base and an exponent.
    typedef struct packed {
        logic [BASE_W-1:0] base;
        logic [EXP_W-1:0]  exponent;
    } power_job_t;

    logic              clk = 1'b0;
    logic              rst_n = 1'b0;
    logic              psel = 1'b0;
    logic              penable = 1'b0;
    logic              pwrite = 1'b0;
    logic [ADDR_W-1:0] paddr = '0;
    logic [31:0]       pwdata = '0;
    logic [31:0]       prdata;
    logic              pready;

    logic              drv_valid = 1'b0;
    logic [BASE_W-1:0] drv_base = '0;
    logic [EXP_W-1:0]  drv_exponent = '0;
    logic              rcv_ready = 1'b0;

    mexp_in_if  in_bus ();
    mexp_out_if out_bus ();

    assign in_bus.valid    = drv_valid;
    assign in_bus.base     = drv_base;
    assign in_bus.exponent = drv_exponent;
    assign out_bus.ready   = rcv_ready;

    power_job_t        pending_jobs[$];
    logic [MOD_W-1:0]  expected_powers[$];
    power_job_t        next_job;
    logic [MOD_W-1:0]  want_power;
    logic [MOD_W-1:0]  modulus_cfg = MODULUS_RESET;
    int unsigned       send_idle_pct = 0;
    int unsigned       recv_idle_pct = 0;
    int unsigned       mismatch_count = 0;
    int unsigned       quiet_cycles = 0;
    int unsigned       hold_left = 0;
    logic              hold_arm = 1'b0;

    modular_exponentiation #(
        .EXP_BITS(EXP_BITS)
    ) u_dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .in_ch   (in_bus),
        .out_ch  (out_bus)
    );

    always #2 clk = ~clk;

    // Right-to-left square-and-multiply; a modulus below two answers zero.
    function automatic logic [MOD_W-1:0] mod_power(input logic [BASE_W-1:0] base,
                                                   input logic [EXP_W-1:0] exponent,
                                                   input logic [MOD_W-1:0] modulus);
        logic [63:0] m;
        logic [63:0] square;
        logic [63:0] acc;
        if (modulus < 2)
            return '0;
        m      = 64'(modulus);
        square = 64'(base) % m;
        acc    = 64'd1;
        for (int i = 0; i < EXP_BITS && i < EXP_W; i++)
        begin
            if (exponent[i])
                acc = (acc * square) % m;
            square = (square * square) % m;
        end
        return acc[MOD_W-1:0];
    endfunction

    // Driver: offers queued words and predicts the result of each accepted one.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (drv_valid && in_bus.ready)
                expected_powers.push_back(mod_power(drv_base, drv_exponent, modulus_cfg));
            if (!drv_valid || in_bus.ready)
            begin
                if (pending_jobs.size() != 0 && $urandom_range(99, 0) >= send_idle_pct)
                begin
                    next_job = pending_jobs.pop_front();
                    drv_valid    <= 1'b1;
                    drv_base     <= next_job.base;
                    drv_exponent <= next_job.exponent;
                end
                else
                begin
                    drv_valid <= 1'b0;
                end
            end
        end
    end

    // Long receiver hold-off, counted here once armed.
    always @(posedge clk)
    begin
        if (!rst_n)
            hold_left <= 0;
        else if (hold_arm && hold_left == 0)
            hold_left <= HOLD_CYCLES;
        else if (hold_left != 0)
            hold_left <= hold_left - 1;
    end

    // Monitor: compares each accepted result word with the oldest prediction.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (out_bus.valid && rcv_ready)
            begin
                if (expected_powers.size() == 0)
                begin
                    $error("power_result: unexpected word, actual %0d", out_bus.power_result);
                    mismatch_count++;
                end
                else
                begin
                    want_power = expected_powers.pop_front();
                    if (out_bus.power_result !== want_power)
                    begin
                        $error("power_result: expected %0d, actual %0d",
                               want_power, out_bus.power_result);
                        mismatch_count++;
                    end
                end
            end
            rcv_ready <= (hold_left == 0) && ($urandom_range(99, 0) >= recv_idle_pct);
        end
    end

    // Watchdog: ends the run when no word moves for too long.
    always @(posedge clk)
    begin
        if (!rst_n || (drv_valid && in_bus.ready) || (out_bus.valid && rcv_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("** modular_exponentiation: FAILED **");
            $finish;
        end
    end

    task automatic queue_word(input logic [BASE_W-1:0] base, input logic [EXP_W-1:0] exponent);
        power_job_t job;
        job.base     = base;
        job.exponent = exponent;
        pending_jobs.push_back(job);
    endtask

    // Waits until every word has been sent and every result has come back.
    task automatic wait_idle();
        do
            @(negedge clk);
        while (pending_jobs.size() != 0 || drv_valid || expected_powers.size() != 0);
    endtask

    // APB write of the modulus register, issued only once the block is idle.
    task automatic write_modulus(input logic [31:0] value);
        wait_idle();
        @(posedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= ADDR_MODULUS;
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        modulus_cfg = value[MOD_W-1:0];
    endtask

    // Writes a modulus and queues random words; most exponents are short to keep runs brief.
    task automatic load_setting(input logic [31:0] value, input int unsigned count);
        int unsigned       pick;
        int unsigned       width;
        logic [BASE_W-1:0] base;
        logic [EXP_W-1:0]  exponent;
        write_modulus(value);
        repeat (count)
        begin
            case ($urandom_range(9, 0))
                0: base = '0;
                1: base = BASE_W'(modulus_cfg);
                2: base = BASE_W'(modulus_cfg) - 1;
                3: base = '1;
                4: base = $urandom_range(16, 0);
                default: base = $urandom;
            endcase
            pick = $urandom_range(99, 0);
            if (pick < 4)
            begin
                exponent = $urandom;
            end
            else
            begin
                width    = (pick < 86) ? $urandom_range(6, 0) : $urandom_range(16, 7);
                exponent = $urandom & ~({EXP_W{1'b1}} << width);
                if (width != 0)
                    exponent[width-1] = 1'b1;
            end
            queue_word(base, exponent);
        end
    endtask

    // Main sequence: reset, directed words, then random phases under varying back-pressure.
    initial
    begin
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;

        // Phase one: sender rarely idles, receiver often stalls.
        send_idle_pct = 7;
        recv_idle_pct = 60;

        // Zero exponents, field extremes and values around the reset modulus.
        queue_word(32'd0, 32'd0);
        queue_word(32'd0, 32'd1);
        queue_word(32'd1, 32'd0);
        queue_word(32'd7, 32'd0);
        queue_word(32'hFFFF_FFFF, 32'd0);
        queue_word(32'hFFFF_FFFF, 32'hFFFF_FFFF);
        queue_word(32'hFFFF_FFFF, 32'd1);
        queue_word(32'd1000000007, 32'd3);
        queue_word(32'd1000000006, 32'd2);
        queue_word(32'd1000000008, 32'hFFFF_FFFF);
        queue_word(32'd2, 32'd30);
        queue_word(32'd2, 32'd31);
        queue_word(32'd3, 32'h8000_0000);
        queue_word(32'd12345, 32'd65537);

        // A modulus of zero or one answers zero.
        write_modulus(32'd0);
        queue_word(32'd5, 32'd3);
        queue_word(32'd0, 32'd0);
        write_modulus(32'd1);
        queue_word(32'd5, 32'd3);
        queue_word(32'd0, 32'd0);

        // Largest modulus, written with the unused top bit set.
        write_modulus(32'hFFFF_FFFF);
        queue_word(32'h7FFF_FFFE, 32'hFFFF_FFFF);
        queue_word(32'h7FFF_FFFF, 32'd2);
        queue_word(32'hFFFF_FFFF, 32'hFFFF_FFFE);

        // Smallest valid modulus.
        write_modulus(32'd2);
        queue_word(32'd3, 32'hFFFF_FFFF);
        queue_word(32'd4, 32'd1);

        load_setting(32'd2, 80);
        load_setting(32'hFFFF_FFFF, 400);

        // Phase two: sender often idles, receiver rarely stalls.
        wait_idle();
        send_idle_pct = 60;
        recv_idle_pct = 7;
        load_setting($urandom_range(32'h7FFF_FFFF, 2), 350);
        load_setting($urandom_range(1000, 3), 350);

        // Phase three: no idling, with one long receiver hold-off to back the block up.
        wait_idle();
        send_idle_pct = 0;
        recv_idle_pct = 0;
        load_setting(32'(MODULUS_RESET), 700);
        @(posedge clk);
        hold_arm <= 1'b1;
        @(posedge clk);
        hold_arm <= 1'b0;

        wait_idle();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (expected_powers.size() != 0)
        begin
            $error("power_result: %0d expected words never arrived", expected_powers.size());
            mismatch_count++;
        end
        if (mismatch_count == 0)
            $display("** modular_exponentiation: PASSED **");
        else
            $display("** modular_exponentiation: FAILED **");
        $finish;
    end

endmodule

/* filelist.f */
rtl/mexp_pkg.sv
rtl/mexp_if.sv
rtl/mexp_mulmod.sv
rtl/mexp_apb.sv
rtl/modular_exponentiation.sv
tb/sv/modular_exponentiation_tb.sv
